### hw/rtl/plpt_pkg.sv
// ----------------------------------------------------------------------------
// plpt_pkg: shared types and constants for the laser plane point pipeline
// Fixed-point formats, register map and calibration reset values.
// ----------------------------------------------------------------------------
package plpt_pkg;

  localparam int NREG   = 8;
  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_CENTER_COL   = 3'd0,
    REG_CENTER_ROW   = 3'd1,
    REG_DISTORTION_K = 3'd2,
    REG_FOCAL_LENGTH = 3'd3,
    REG_PLANE_A      = 3'd4,
    REG_PLANE_B      = 3'd5,
    REG_PLANE_C      = 3'd6,
    REG_PLANE_D      = 3'd7
  } reg_idx_t;

  // pixel pitch in metres, Q48
  localparam logic signed [31:0] SX_Q48   = 32'sd1491946855;
  localparam logic signed [31:0] SY_Q48   = 32'sd1491817377;
  // millimetres with 16 fraction bits: 1000 * 2^16
  localparam logic [25:0]        MM_SCALE = 26'd65536000;

  localparam logic [15:0] RST_CENTER_COL   = 16'd10117;
  localparam logic [15:0] RST_CENTER_ROW   = 16'd7581;
  localparam logic [31:0] RST_DISTORTION_K = 32'hFFFA_40BB;
  localparam logic [30:0] RST_FOCAL_LENGTH = 31'd36474709;
  localparam logic [31:0] RST_PLANE_A      = 32'd2049140;
  localparam logic [31:0] RST_PLANE_B      = 32'd46465;
  localparam logic [31:0] RST_PLANE_C      = 32'hFFF3_BF63;
  localparam logic [31:0] RST_PLANE_D      = 32'd65536;

  localparam int UW   = 28;  // u, v: metres Q32
  localparam int R2W  = 31;  // r^2: square metres Q40
  localparam int FKW  = 27;  // f*kt: metres Q24
  localparam int DENW = 60;  // denominator, Q40, signed
  localparam int NUMW = 59;  // numerators, Q40, signed
  localparam int DMW  = 59;  // denominator magnitude
  localparam int NMW  = 58;  // numerator magnitude
  localparam int NW   = 84;  // scaled dividend
  localparam int QW   = 32;  // quotient bits
  localparam int NCH  = 3;   // x, y, z
  localparam int LAT  = 14 + QW;

endpackage

### hw/rtl/pixel_to_laser_plane_point.sv
// ----------------------------------------------------------------------------
// pixel_to_laser_plane_point: laser plane triangulation of one image point
// Maps a subpixel laser-line point to a camera-frame point in millimetres.
// ----------------------------------------------------------------------------
// A point is taken on every cycle that start is high (busy never rises), and
// its result appears as a one-cycle beat on done with point_x/y/z and
// degenerate; throughput is one point per clock. The pipeline is built from
// 13 arithmetic stages (offset, pitch scaling, squares, distortion, focal
// scaling, plane products, denominator, magnitudes, mm scaling, overflow
// check), a 32-stage restoring divider, one quotient bit per stage, three
// lanes side by side for x, y and z sharing the denominator, and a final
// output register. The receiver cannot stall, so
// there is no back-pressure anywhere. A zero denominator flags degenerate and
// drives zeros; quotients beyond 32 bits signed saturate. Write the APB
// registers only while no point is in flight.
module pixel_to_laser_plane_point
  import plpt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [15:0]       pixel_row,
  input  logic [15:0]       pixel_col,
  output logic              done,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z,
  output logic              degenerate,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0]        center_col;
  logic [15:0]        center_row;
  logic signed [31:0] distortion_k;
  logic [30:0]        focal_length;
  logic signed [31:0] plane_a;
  logic signed [31:0] plane_b;
  logic signed [31:0] plane_c;
  logic signed [31:0] plane_d;
  reg_idx_t           reg_sel;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_sel = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      center_col   <= RST_CENTER_COL;
      center_row   <= RST_CENTER_ROW;
      distortion_k <= RST_DISTORTION_K;
      focal_length <= RST_FOCAL_LENGTH;
      plane_a      <= RST_PLANE_A;
      plane_b      <= RST_PLANE_B;
      plane_c      <= RST_PLANE_C;
      plane_d      <= RST_PLANE_D;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_CENTER_COL:   center_col   <= pwdata[15:0];
        REG_CENTER_ROW:   center_row   <= pwdata[15:0];
        REG_DISTORTION_K: distortion_k <= pwdata;
        REG_FOCAL_LENGTH: focal_length <= pwdata[30:0];
        REG_PLANE_A:      plane_a      <= pwdata;
        REG_PLANE_B:      plane_b      <= pwdata;
        REG_PLANE_C:      plane_c      <= pwdata;
        REG_PLANE_D:      plane_d      <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_CENTER_COL:   prdata = {16'd0, center_col};
      REG_CENTER_ROW:   prdata = {16'd0, center_row};
      REG_DISTORTION_K: prdata = distortion_k;
      REG_FOCAL_LENGTH: prdata = {1'b0, focal_length};
      REG_PLANE_A:      prdata = plane_a;
      REG_PLANE_B:      prdata = plane_b;
      REG_PLANE_C:      prdata = plane_c;
      REG_PLANE_D:      prdata = plane_d;
      default:          prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Valid bits: one per stage, shifted alongside the data
  // --------------------------------------------------------------------------
  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end

  assign done = vld[LAT-1];

  // --------------------------------------------------------------------------
  // Stage 1: offset by the principal point
  // --------------------------------------------------------------------------
  logic signed [16:0] dcol;
  logic signed [16:0] drow;

  always_ff @(posedge clk) begin
    dcol <= $signed({1'b0, pixel_col}) - $signed({1'b0, center_col});
    drow <= $signed({1'b0, pixel_row}) - $signed({1'b0, center_row});
  end

  // --------------------------------------------------------------------------
  // Stage 2: scale by pixel pitch into sensor metres (Q32)
  // --------------------------------------------------------------------------
  logic signed [47:0]   pu_prod;
  logic signed [47:0]   pv_prod;
  logic signed [UW-1:0] u;
  logic signed [UW-1:0] v;

  assign pu_prod = SX_Q48 * dcol;
  assign pv_prod = SY_Q48 * drow;

  always_ff @(posedge clk) begin
    u <= pu_prod[47:20];
    v <= pv_prod[47:20];
  end

  // --------------------------------------------------------------------------
  // Stage 3: squares and plane products of u, v
  // --------------------------------------------------------------------------
  logic signed [55:0] uu;
  logic signed [55:0] vv;
  logic signed [59:0] au;
  logic signed [59:0] bv;
  logic signed [59:0] du;
  logic signed [59:0] dv;

  always_ff @(posedge clk) begin
    uu <= u * u;
    vv <= v * v;
    au <= plane_a * u;
    bv <= plane_b * v;
    du <= plane_d * u;
    dv <= plane_d * v;
  end

  // --------------------------------------------------------------------------
  // Stage 4: radius squared, partial denominator, x/y numerators
  // --------------------------------------------------------------------------
  logic [56:0]            rsum;
  logic [R2W-1:0]         r2;
  logic signed [DENW-1:0] ab;
  logic signed [NUMW-1:0] nx;
  logic signed [NUMW-1:0] ny;

  assign rsum = 57'(uu) + 57'(vv);

  always_ff @(posedge clk) begin
    r2 <= rsum[54:24];
    ab <= DENW'(au >>> 8) + DENW'(bv >>> 8);
    nx <= -NUMW'(du >>> 8);
    ny <= -NUMW'(dv >>> 8);
  end

  // hold partial denominator and numerators until the z path catches up
  logic signed [DENW-1:0] ab_d [4];
  logic signed [NUMW-1:0] nx_d [4];
  logic signed [NUMW-1:0] ny_d [4];

  always_ff @(posedge clk) begin
    ab_d[0] <= ab;
    nx_d[0] <= nx;
    ny_d[0] <= ny;
    for (int i = 1; i < 4; i++) begin
      ab_d[i] <= ab_d[i-1];
      nx_d[i] <= nx_d[i-1];
      ny_d[i] <= ny_d[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: K * r^2
  // --------------------------------------------------------------------------
  logic signed [63:0] kr;

  always_ff @(posedge clk) begin
    kr <= distortion_k * $signed({1'b0, r2});
  end

  // --------------------------------------------------------------------------
  // Stage 6: kt = K r^2 + 1, Q28, saturated to 32 bits
  // --------------------------------------------------------------------------
  localparam logic signed [44:0] KT_MAX = 45'sd2147483647;
  localparam logic signed [44:0] KT_MIN = -45'sd2147483648;

  logic signed [48:0] kt32;
  logic signed [44:0] kt_full;
  logic signed [31:0] kt;

  assign kt32    = 49'(kr >>> 16) + 49'sd4294967296;
  assign kt_full = kt32[48:4];

  always_ff @(posedge clk) begin
    if (kt_full > KT_MAX) begin
      kt <= 32'sh7FFF_FFFF;
    end else if (kt_full < KT_MIN) begin
      kt <= 32'sh8000_0000;
    end else begin
      kt <= kt_full[31:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 7: f * kt
  // --------------------------------------------------------------------------
  logic signed [63:0] fkp;

  always_ff @(posedge clk) begin
    fkp <= $signed({1'b0, focal_length}) * kt;
  end

  // --------------------------------------------------------------------------
  // Stage 8: C * fk and D * fk
  // --------------------------------------------------------------------------
  logic signed [FKW-1:0] fk;
  logic signed [58:0]    cf;
  logic signed [58:0]    df;

  assign fk = fkp[62:36];

  always_ff @(posedge clk) begin
    cf <= plane_c * fk;
    df <= plane_d * fk;
  end

  // --------------------------------------------------------------------------
  // Stage 9: denominator and the three numerators
  // --------------------------------------------------------------------------
  logic signed [DENW-1:0] den;
  logic signed [NUMW-1:0] num [NCH];

  always_ff @(posedge clk) begin
    den    <= ab_d[3] + DENW'(cf);
    num[0] <= nx_d[3];
    num[1] <= ny_d[3];
    num[2] <= -df;
  end

  // --------------------------------------------------------------------------
  // Stage 10: magnitudes, signs, degenerate flag
  // --------------------------------------------------------------------------
  logic [DMW-1:0] dm10;
  logic           deg10;
  logic [NMW-1:0] nm   [NCH];
  logic           neg10 [NCH];

  always_ff @(posedge clk) begin
    dm10  <= den[DENW-1] ? DMW'(-den) : DMW'(den);
    deg10 <= (den == '0);
    for (int c = 0; c < NCH; c++) begin
      nm[c]    <= num[c][NUMW-1] ? NMW'(-num[c]) : NMW'(num[c]);
      neg10[c] <= num[c][NUMW-1] ^ den[DENW-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 11: numerator times 1000 * 2^16, split in two partial products
  // --------------------------------------------------------------------------
  logic [DMW-1:0] dm11;
  logic           deg11;
  logic [57:0]    pl    [NCH];
  logic [51:0]    ph    [NCH];
  logic           neg11 [NCH];

  always_ff @(posedge clk) begin
    dm11  <= dm10;
    deg11 <= deg10;
    for (int c = 0; c < NCH; c++) begin
      pl[c]    <= nm[c][31:0] * MM_SCALE;
      ph[c]    <= nm[c][NMW-1:32] * MM_SCALE;
      neg11[c] <= neg10[c];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 12: join partial products into the dividend
  // --------------------------------------------------------------------------
  logic [DMW-1:0] dm12;
  logic           deg12;
  logic [NW-1:0]  nn    [NCH];
  logic           neg12 [NCH];

  always_ff @(posedge clk) begin
    dm12  <= dm11;
    deg12 <= deg11;
    for (int c = 0; c < NCH; c++) begin
      nn[c]    <= {ph[c], 32'd0} + NW'(pl[c]);
      neg12[c] <= neg11[c];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 13 and divider: index 0 is the overflow check, then one quotient
  // bit per stage. If the upper dividend reaches the divisor the quotient
  // needs more than 32 bits, so flag saturation and let the lane run on.
  // --------------------------------------------------------------------------
  logic [DMW-1:0] dm_p  [QW+1];
  logic           deg_p [QW+1];
  logic [DMW-1:0] rem   [NCH][QW+1];
  logic [QW-1:0]  low   [NCH][QW+1];
  logic           neg_p [NCH][QW+1];
  logic           sat_p [NCH][QW+1];

  always_ff @(posedge clk) begin
    dm_p[0]  <= dm12;
    deg_p[0] <= deg12;
    for (int c = 0; c < NCH; c++) begin
      rem[c][0]   <= DMW'(nn[c][NW-1:QW]);
      low[c][0]   <= nn[c][QW-1:0];
      neg_p[c][0] <= neg12[c];
      sat_p[c][0] <= DMW'(nn[c][NW-1:QW]) >= dm12;
    end
  end

  for (genvar s = 0; s < QW; s++) begin : g_div
    always_ff @(posedge clk) begin
      dm_p[s+1]  <= dm_p[s];
      deg_p[s+1] <= deg_p[s];
    end

    for (genvar c = 0; c < NCH; c++) begin : g_lane
      logic [DMW:0] trial;
      logic [DMW:0] diff;
      logic         ge;

      assign trial = {rem[c][s], low[c][s][QW-1]};
      assign diff  = trial - {1'b0, dm_p[s]};
      assign ge    = trial >= {1'b0, dm_p[s]};

      always_ff @(posedge clk) begin
        rem[c][s+1]   <= ge ? diff[DMW-1:0] : trial[DMW-1:0];
        low[c][s+1]   <= {low[c][s][QW-2:0], ge};
        neg_p[c][s+1] <= neg_p[c][s];
        sat_p[c][s+1] <= sat_p[c][s];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: sign, saturation, degenerate zeroing
  // --------------------------------------------------------------------------
  logic signed [31:0] res [NCH];

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      if (deg_p[QW]) begin
        res[c] = 32'sd0;
      end else if (sat_p[c][QW]) begin
        res[c] = neg_p[c][QW] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else if (neg_p[c][QW]) begin
        res[c] = (low[c][QW] > 32'h8000_0000) ? 32'sh8000_0000
                                              : $signed(32'd0 - low[c][QW]);
      end else begin
        res[c] = (low[c][QW] > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF
                                              : $signed(low[c][QW]);
      end
    end
  end

  always_ff @(posedge clk) begin
    point_x    <= res[0];
    point_y    <= res[1];
    point_z    <= res[2];
    degenerate <= deg_p[QW];
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted point did not complete after the pipeline latency");

  a_no_phantom : assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> $past(start, LAT))
    else $error("result beat without a matching accepted point");

  a_degenerate_zero : assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (point_x == 32'sd0 && point_y == 32'sd0 && point_z == 32'sd0))
    else $error("degenerate result with non-zero coordinates");

  a_plane_d_write : assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && reg_sel == REG_PLANE_D) |=> (plane_d == $past(pwdata)))
    else $error("plane_d write not taken");

endmodule
